@@ hw/rtl/dpt_pkg.sv @@
// Shared constants and field layout for the demand paging translator.
// No dependencies; imported by the translator top level.
`timescale 1ns / 1ps

package dpt_pkg;

    // Fixed field widths of the stream payloads
    localparam int CMD_W      = 1;
    localparam int PAGE_W     = 3;
    localparam int OFFSET_W   = 7;
    localparam int PRE_BLK_W  = 5;
    localparam int ADDR_W     = 12;
    localparam int BLK_FIELD_W = 5;

    // Units per page
    localparam int PAGE_SIZE  = 128;

    // Slave tdata: page_number, offset, preload_block, padded to bytes
    localparam int IN_FIELDS_W = PAGE_W + OFFSET_W + PRE_BLK_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W   = CMD_W;

    // Master tdata: phys_address, block_number, padded to bytes
    localparam int OUT_FIELDS_W = ADDR_W + BLK_FIELD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ACCESS  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PRELOAD = 1'b1;

    // Result item as held in the output register
    typedef struct packed {
        logic [ADDR_W-1:0]      phys_address;
        logic [BLK_FIELD_W-1:0] block_number;
        logic                   page_fault;
        logic                   out_of_memory;
    } result_t;

endpackage

@@ hw/rtl/dpt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the page table block numbers.
`timescale 1ns / 1ps

module dpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/dpt_free_finder.sv @@
// Registered lowest-free-block search over the block usage map.
// No dependencies; instantiated by the translator top level.
`timescale 1ns / 1ps

module dpt_free_finder #(
    parameter int NUM_BLOCKS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [NUM_BLOCKS-1:0]         used_map,
    output logic                          free_found,
    output logic [$clog2(NUM_BLOCKS)-1:0] free_idx
);

    localparam int BW = $clog2(NUM_BLOCKS);

    logic          found_next;
    logic [BW-1:0] idx_next;
    logic          found_reg;
    logic [BW-1:0] idx_reg;

    // Scan from the top so the lowest clear bit wins
    always_comb
    begin
        idx_next   = '0;
        found_next = ~(&used_map);
        for (int i = NUM_BLOCKS - 1; i >= 0; i--)
        begin
            if (!used_map[i])
            begin
                idx_next = BW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    assign free_found = found_reg;
    assign free_idx   = idx_reg;

endmodule

@@ hw/rtl/demand_paging_translator.sv @@
// An accepted item takes the FSM to EXEC, which loads the output register and m_axis_tvalid.
// s_axis_tready is high only in IDLE: no new item is taken before the read-modify-write
// of the page table RAM (read at acceptance, update in EXEC) ends; a stalled master holds it.
// Reset: page present bits and the block usage map are flip-flops cleared at once;
// no clearing pass, the block is ready in the first cycle after reset.
// Depends on dpt_pkg, dpt_ram and dpt_free_finder.
`timescale 1ns / 1ps

module demand_paging_translator #(
    parameter int NUM_PAGES  = 8,
    parameter int NUM_BLOCKS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // page_number [2:0], offset [9:3], preload_block [14:10], zero pad above
    input  logic [dpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command [0]
    input  logic [dpt_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // phys_address [11:0], block_number [16:12], zero pad above
    output logic [dpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // page_fault [0], out_of_memory [1]
    output logic [dpt_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    import dpt_pkg::*;

    localparam int PW = $clog2(NUM_PAGES);
    localparam int BW = $clog2(NUM_BLOCKS);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0]              state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg;
    logic [PAGE_W-1:0]       page_reg;
    logic [OFFSET_W-1:0]     off_reg;
    logic [PRE_BLK_W-1:0]    pre_reg;
    logic [NUM_PAGES-1:0]    valid_reg, valid_next;
    logic [NUM_BLOCKS-1:0]   used_map_reg, used_map_next;
    logic                    out_valid_reg;
    result_t                 out_reg, out_next;

    logic                    accept;
    logic                    out_free;
    logic                    exec_go;
    logic [PAGE_W-1:0]       in_page;
    logic [PW-1:0]           page_idx;
    logic [BW-1:0]           pre_blk;
    logic [BW-1:0]           ram_rdata;
    logic                    ram_we;
    logic [BW-1:0]           ram_wdata;
    logic                    free_found;
    logic [BW-1:0]           free_idx;
    logic                    page_ok;
    logic                    pre_ok;
    logic                    present;
    logic                    set_used;
    logic [BW-1:0]           set_blk;
    logic                    fault_c;
    logic [31:0]             addr_wide;
    logic [BW-1:0]           res_blk;

    assign in_page  = s_axis_tdata[PAGE_W-1:0];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign exec_go  = (state_reg == ST_EXEC) && out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);

    assign page_idx = PW'(page_reg);
    assign pre_blk  = BW'(pre_reg);
    assign page_ok  = (32'(page_reg) < NUM_PAGES);
    assign pre_ok   = (32'(pre_reg) < NUM_BLOCKS);
    assign present  = page_ok && valid_reg[page_idx];

    dpt_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_PAGES)
    ) u_page_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (page_idx),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (PW'(in_page)),
        .rdata (ram_rdata)
    );

    dpt_free_finder #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_free_finder (
        .clk        (clk),
        .rst_n      (rst_n),
        .used_map   (used_map_reg),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    // Resolve the item against the page table entry read at acceptance
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        set_used  = 1'b0;
        set_blk   = '0;
        fault_c   = 1'b0;
        res_blk   = '0;
        out_next  = '0;
        addr_wide = '0;
        priority if (!page_ok || (cmd_reg == CMD_PRELOAD && !pre_ok))
        begin
            out_next = '0;
        end
        else if (cmd_reg == CMD_PRELOAD)
        begin
            ram_we                = 1'b1;
            ram_wdata             = pre_blk;
            set_used              = 1'b1;
            set_blk               = pre_blk;
            out_next.block_number = BLK_FIELD_W'(pre_blk);
        end
        else if (present)
        begin
            res_blk               = ram_rdata;
            addr_wide             = 32'(res_blk) * PAGE_SIZE + 32'(off_reg);
            out_next.phys_address = addr_wide[ADDR_W-1:0];
            out_next.block_number = BLK_FIELD_W'(res_blk);
        end
        else if (!free_found)
        begin
            out_next.out_of_memory = 1'b1;
        end
        else
        begin
            // Allocate the lowest free block
            fault_c               = 1'b1;
            res_blk               = free_idx;
            ram_we                = 1'b1;
            ram_wdata             = free_idx;
            set_used              = 1'b1;
            set_blk               = free_idx;
            addr_wide             = 32'(res_blk) * PAGE_SIZE + 32'(off_reg);
            out_next.phys_address = addr_wide[ADDR_W-1:0];
            out_next.block_number = BLK_FIELD_W'(res_blk);
            out_next.page_fault   = 1'b1;
        end
        // Drop all writes unless the update really happens this cycle
        ram_we   = ram_we && exec_go;
        set_used = set_used && exec_go;
    end

    always_comb
    begin
        valid_next    = valid_reg;
        used_map_next = used_map_reg;
        if (ram_we)
        begin
            valid_next[page_idx] = 1'b1;
        end
        if (set_used)
        begin
            used_map_next[set_blk] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            used_map_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            used_map_reg <= used_map_next;
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_axis_tuser[CMD_W-1:0];
            page_reg <= in_page;
            off_reg  <= s_axis_tdata[PAGE_W +: OFFSET_W];
            pre_reg  <= s_axis_tdata[PAGE_W + OFFSET_W +: PRE_BLK_W];
        end
        if (exec_go)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            out_reg.block_number, out_reg.phys_address};
    assign m_axis_tuser  = {out_reg.out_of_memory, out_reg.page_fault};

    a_exec_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> m_axis_tvalid)
        else $error("resolved transaction did not reach the output register");

    a_fault_oom_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("page fault and out of memory flagged together");

    a_fault_takes_one_block: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && fault_c) |=>
            ($countones(used_map_reg) == $past($countones(used_map_reg)) + 1))
        else $error("page fault did not allocate exactly one new block");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && !out_free) |=> (state_reg == ST_EXEC)
            && $stable(used_map_reg) && $stable(valid_reg))
        else $error("state changed while the result path was stalled");

endmodule

@@ sim/dpt_checker.sv @@
// Checker for the demand paging translator: watches both stream channels,
// predicts each result from its own page table copy and compares in order.
// Depends on dpt_pkg for field widths, command codes and the result layout.
`timescale 1ns / 1ps

module dpt_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dpt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [dpt_pkg::IN_USER_W-1:0]   s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dpt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [dpt_pkg::OUT_USER_W-1:0]  m_tuser,
    output int                              mismatch_count,
    output int                              pending_count
);

    import dpt_pkg::*;

    localparam int PAGES  = 8;
    localparam int BLOCKS = 32;

    bit                     page_mapped [PAGES];
    logic [BLK_FIELD_W-1:0] page_frame  [PAGES];
    logic [BLOCKS-1:0]      frame_used;
    result_t                pending_translations [$];

    // Update the page table copy and return the result one transaction causes
    function automatic result_t predict_translation(
        input logic [CMD_W-1:0]     cmd,
        input logic [PAGE_W-1:0]    page,
        input logic [OFFSET_W-1:0]  off,
        input logic [PRE_BLK_W-1:0] pre
    );
        result_t                r;
        logic [BLK_FIELD_W-1:0] frame;
        bit                     found;
        r = '0;
        if (page >= PAGES)
            return r;
        if (cmd == CMD_PRELOAD)
        begin
            if (pre >= BLOCKS)
                return r;
            page_mapped[page] = 1'b1;
            page_frame[page]  = pre;
            frame_used[pre]   = 1'b1;
            r.block_number    = pre;
            return r;
        end
        if (page_mapped[page])
            frame = page_frame[page];
        else
        begin
            found = 1'b0;
            frame = '0;
            for (int i = 0; i < BLOCKS; i++)
            begin
                if (!found && !frame_used[i])
                begin
                    found = 1'b1;
                    frame = BLK_FIELD_W'(i);
                end
            end
            // No free block: flag it and leave the tables alone
            if (!found)
            begin
                r.out_of_memory = 1'b1;
                return r;
            end
            frame_used[frame] = 1'b1;
            page_mapped[page] = 1'b1;
            page_frame[page]  = frame;
            r.page_fault      = 1'b1;
        end
        r.phys_address = ADDR_W'(frame * PAGE_SIZE + off);
        r.block_number = frame;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < PAGES; i++)
            begin
                page_mapped[i] = 1'b0;
                page_frame[i]  = '0;
            end
            frame_used = '0;
            pending_translations.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            // Retire first: a result never belongs to the transaction taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (pending_translations.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_translations.pop_front();
                    compare_field("phys_address", want.phys_address, m_tdata[ADDR_W-1:0]);
                    compare_field("block_number", ADDR_W'(want.block_number),
                                  ADDR_W'(m_tdata[ADDR_W +: BLK_FIELD_W]));
                    compare_field("page_fault", ADDR_W'(want.page_fault), ADDR_W'(m_tuser[0]));
                    compare_field("out_of_memory", ADDR_W'(want.out_of_memory),
                                  ADDR_W'(m_tuser[1]));
                end
            end
            if (s_tvalid && s_tready)
                pending_translations.push_back(predict_translation(
                    s_tuser[CMD_W-1:0],
                    s_tdata[PAGE_W-1:0],
                    s_tdata[PAGE_W +: OFFSET_W],
                    s_tdata[PAGE_W + OFFSET_W +: PRE_BLK_W]));
            pending_count = pending_translations.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the demand paging translator: clock, reset, stimulus and verdict.
// Depends on dpt_pkg, demand_paging_translator and dpt_checker.
`timescale 1ns / 1ps

module tb;
    import dpt_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // page_number, offset, preload_block, zero pad
    logic [IN_USER_W-1:0]   s_axis_tuser;   // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // phys_address, block_number, zero pad
    logic [OUT_USER_W-1:0]  m_axis_tuser;   // page_fault, out_of_memory
    int                     mismatch_count;
    int                     pending_count;
    bit                     quiet;

    demand_paging_translator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dpt_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tuser        (s_axis_tuser),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with tvalid still high.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] page,
                             input logic [OFFSET_W-1:0] off,
                             input logic [PRE_BLK_W-1:0] blk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({blk, off, page});
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sink side: random stall bursts until the quiet tail
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int frame_order [32];
        int pick;
        int swap;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        quiet         = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Faults, hits, remaps and preloads onto used blocks; page 7 stays unmapped
        send_item(CMD_ACCESS,  3'd0, 7'd0,   5'd0);
        send_item(CMD_ACCESS,  3'd0, 7'd127, 5'd31);
        send_item(CMD_ACCESS,  3'd3, 7'd64,  5'd0);
        send_item(CMD_PRELOAD, 3'd1, 7'd0,   5'd31);
        send_item(CMD_ACCESS,  3'd1, 7'd127, 5'd0);
        send_item(CMD_PRELOAD, 3'd2, 7'd127, 5'd0);
        send_item(CMD_ACCESS,  3'd2, 7'd1,   5'd0);
        send_item(CMD_PRELOAD, 3'd0, 7'd0,   5'd5);
        send_item(CMD_ACCESS,  3'd0, 7'd3,   5'd0);
        send_item(CMD_ACCESS,  3'd4, 7'd0,   5'd0);
        send_item(CMD_ACCESS,  3'd5, 7'd100, 5'd0);
        send_item(CMD_ACCESS,  3'd6, 7'd0,   5'd0);
        send_item(CMD_ACCESS,  3'd6, 7'd127, 5'd31);

        // Claim every block in shuffled order so that page 7 finds memory full
        for (int i = 0; i < 32; i++)
            frame_order[i] = i;
        for (int i = 31; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            swap = frame_order[i];
            frame_order[i] = frame_order[pick];
            frame_order[pick] = swap;
        end
        for (int i = 0; i < 32; i++)
        begin
            send_item(CMD_PRELOAD, PAGE_W'($urandom_range(0, 6)), OFFSET_W'($urandom),
                      PRE_BLK_W'(frame_order[i]));
            if ($urandom_range(0, 1) == 0)
                send_item(CMD_ACCESS, PAGE_W'($urandom_range(0, 6)), OFFSET_W'($urandom),
                          PRE_BLK_W'($urandom));
        end
        send_item(CMD_ACCESS, 3'd7, 7'd0,   5'd0);
        send_item(CMD_ACCESS, 3'd7, 7'd127, 5'd31);
        repeat (4)
            send_item(CMD_ACCESS, 3'd7, OFFSET_W'($urandom), PRE_BLK_W'($urandom));
        send_item(CMD_PRELOAD, 3'd7, OFFSET_W'($urandom), PRE_BLK_W'($urandom));

        // Random mix over the fully mapped table, calm tail at the end
        for (int i = 0; i < 1550; i++)
        begin
            if (i == 1350)
                quiet = 1'b1;
            send_item(($urandom_range(0, 3) == 0) ? CMD_PRELOAD : CMD_ACCESS,
                      PAGE_W'($urandom), OFFSET_W'($urandom), PRE_BLK_W'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_count == 0);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
